// ===== rtl/core/bbm_pkg.sv =====
package bbm_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned INC_W = 31;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned BITS_W = 6;
   localparam int unsigned CYC_W = 3;
   localparam int unsigned STAGE_W = 3;
   localparam int unsigned CSR_IDX_W = 1;

   localparam int unsigned PRE_ZERO_BITS = 32;
   localparam int unsigned SYNC_BITS = 32;
   localparam int unsigned POST_ZERO_BITS = 16;
   localparam int unsigned PACKET_BITS = 32;
   localparam int unsigned CHECK_BITS = 16;

   localparam logic [CYC_W-1:0] CYCLES_PER_BIT = 3'd4;
   localparam logic [WORD_W-1:0] SYNC_PATTERN = 32'h5555_5555;
   localparam logic [WORD_W-1:0] XOR_MASK = 32'h1fff_0000;
   localparam logic [INC_W-1:0] PHASE_INC_RESET = 31'd858993459;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_WORD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_INC = 1'd1;

   // burst sections
   localparam logic [STAGE_W-1:0] ST_IDLE = 3'd0;
   localparam logic [STAGE_W-1:0] ST_PRE = 3'd1;
   localparam logic [STAGE_W-1:0] ST_SYNC = 3'd2;
   localparam logic [STAGE_W-1:0] ST_WORD = 3'd3;
   localparam logic [STAGE_W-1:0] ST_XWORD = 3'd4;
   localparam logic [STAGE_W-1:0] ST_CHECK = 3'd5;
   localparam logic [STAGE_W-1:0] ST_POST = 3'd6;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // quarter wave, entry 64 is the peak
   localparam logic signed [SAMPLE_W-1:0] QUARTER_SINE [0:64] = '{
      16'sd0, 16'sd784, 16'sd1569, 16'sd2352, 16'sd3134, 16'sd3914, 16'sd4692, 16'sd5467,
      16'sd6239, 16'sd7007, 16'sd7770, 16'sd8529, 16'sd9283, 16'sd10031, 16'sd10774,
      16'sd11509, 16'sd12238, 16'sd12960, 16'sd13673, 16'sd14379, 16'sd15075, 16'sd15763,
      16'sd16441, 16'sd17109, 16'sd17767, 16'sd18414, 16'sd19051, 16'sd19675, 16'sd20288,
      16'sd20889, 16'sd21477, 16'sd22052, 16'sd22613, 16'sd23162, 16'sd23696, 16'sd24216,
      16'sd24721, 16'sd25212, 16'sd25687, 16'sd26147, 16'sd26591, 16'sd27019, 16'sd27431,
      16'sd27826, 16'sd28204, 16'sd28566, 16'sd28910, 16'sd29237, 16'sd29546, 16'sd29838,
      16'sd30111, 16'sd30366, 16'sd30603, 16'sd30822, 16'sd31022, 16'sd31203, 16'sd31366,
      16'sd31510, 16'sd31634, 16'sd31740, 16'sd31827, 16'sd31894, 16'sd31942, 16'sd31971,
      16'sd31981
   };

   // full-turn sine from the quarter wave by symmetry
   function automatic sample_type sine_at(input logic [7:0] idx);
      logic [6:0] q;
      logic neg;
      sample_type mag;
      if (idx <= 8'd64) begin
         q = idx[6:0];
         neg = 1'b0;
      end else if (idx < 8'd128) begin
         q = 7'(8'd128 - idx);
         neg = 1'b0;
      end else if (idx <= 8'd192) begin
         q = 7'(idx - 8'd128);
         neg = 1'b1;
      end else begin
         q = 7'(9'd256 - {1'b0, idx});
         neg = 1'b1;
      end
      mag = QUARTER_SINE[q];
      return neg ? -mag : mag;
   endfunction

endpackage

// ===== rtl/core/bpsk_burst_modulator_top.sv =====
// BPSK burst modulator.
// Request channel (req_*): one request asks for one audio sample; req_start_req
// set restarts the burst from the preamble with the carrier phase at zero.
// Response channel (rsp_*): exactly one response per request, in order:
// rsp_sample (signed, 0 when idle), rsp_active (sample is part of a burst) and
// rsp_last (final burst sample).
// A burst sends zero preamble bits, sync bits, the packet word, the packet word
// with its check mask applied, its top 16 bits and zero postamble bits, MSB
// first, four carrier cycles per bit; a bit change flips the carrier by 180 degrees.
// Configuration (csr_*): index 0 packet word, index 1 phase increment; write
// only while no request is outstanding.
// Each response is registered, in the skid register while a response is held.
// Throughput: one request per cycle while req_stall is low; the per-sample work
// is one 32-bit phase add, a bit select and a sine table read, all combinational.
// A response register plus a skid register let one more request in while a
// response is held; req_stall rises only when both are full.
// Reset: idle, phase zero, phase increment 858993459, packet word zero.
module bpsk_burst_modulator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_start_req,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [bbm_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                             rsp_active,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [bbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bbm_pkg::WORD_W-1:0]       csr_wdata
);
   import bbm_pkg::*;

   // configuration
   logic [WORD_W-1:0] packet_word_ff;
   logic [INC_W-1:0]  phase_inc_ff;

   // burst state
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [WORD_W-1:0]  shift_ff, shift_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic [CYC_W-1:0]   cycles_ff, cycles_in;
   logic [WORD_W-1:0]  phase_ff, phase_in;
   logic               wrap_ff, wrap_in;
   logic               flip_ff, flip_in;
   logic               prev_ff, prev_in;

   // per-request result
   sample_type res_sample;
   logic       res_active;
   logic       res_last;

   logic [WORD_W:0] phase_sum;
   logic [7:0]      sine_idx;
   logic            cur_bit;

   // response register and skid register
   logic       out_valid_ff, skid_valid_ff;
   sample_type out_sample_ff, skid_sample_ff;
   logic       out_active_ff, skid_active_ff;
   logic       out_last_ff, skid_last_ff;

   logic accept;
   logic out_free;

   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_active = out_active_ff;
   assign rsp_last = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_word_ff <= '0;
         phase_inc_ff <= PHASE_INC_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PACKET_WORD: packet_word_ff <= csr_wdata;
            CSR_PHASE_INC:   phase_inc_ff <= csr_wdata[INC_W-1:0];
            default: ;
         endcase
      end
   end

   // next burst state and sample for the request at the port
   always_comb begin
      stage_in = stage_ff;
      shift_in = shift_ff;
      bits_in = bits_ff;
      cycles_in = cycles_ff;
      phase_in = phase_ff;
      wrap_in = wrap_ff;
      flip_in = flip_ff;
      prev_in = prev_ff;
      res_sample = '0;
      res_active = 1'b0;
      res_last = 1'b0;
      phase_sum = '0;
      sine_idx = '0;
      cur_bit = 1'b0;

      // restart: preamble loaded, carrier back to zero
      if (req_start_req) begin
         phase_in = '0;
         wrap_in = 1'b0;
         shift_in = '0;
         bits_in = BITS_W'(PRE_ZERO_BITS);
         cycles_in = CYCLES_PER_BIT;
         stage_in = ST_PRE;
         flip_in = 1'b0;
         prev_in = 1'b0;
      end

      // count the carrier wrap seen on the previous sample, even when idle
      if (wrap_in) begin
         wrap_in = 1'b0;
         cycles_in = cycles_in - 3'd1;
      end

      if (stage_in >= ST_PRE && stage_in <= ST_POST) begin
         // advance to the next bit after four carrier cycles
         if (cycles_in == '0) begin
            cycles_in = CYCLES_PER_BIT;
            if (bits_in != '0) begin
               bits_in = bits_in - 6'd1;
               cur_bit = shift_in[bits_in[4:0]];
               if (cur_bit != prev_in) begin
                  prev_in = cur_bit;
                  flip_in = ~flip_in;
               end
            end
         end

         // section drained: load the next one
         if (bits_in == '0) begin
            cycles_in = CYCLES_PER_BIT;
            unique case (stage_in)
               ST_PRE: begin
                  stage_in = ST_SYNC;
                  shift_in = SYNC_PATTERN;
                  bits_in = BITS_W'(SYNC_BITS);
               end
               ST_SYNC: begin
                  stage_in = ST_WORD;
                  shift_in = packet_word_ff;
                  bits_in = BITS_W'(PACKET_BITS);
               end
               ST_WORD: begin
                  stage_in = ST_XWORD;
                  shift_in = packet_word_ff ^ XOR_MASK;
                  bits_in = BITS_W'(PACKET_BITS);
               end
               ST_XWORD: begin
                  stage_in = ST_CHECK;
                  shift_in = {16'd0, packet_word_ff[31:16]};
                  bits_in = BITS_W'(CHECK_BITS);
               end
               ST_CHECK: begin
                  stage_in = ST_POST;
                  shift_in = '0;
                  bits_in = BITS_W'(POST_ZERO_BITS);
               end
               default: begin
                  // postamble done: the burst ends on this sample
                  cycles_in = cycles_ff - (wrap_ff && !req_start_req ? 3'd1 : 3'd0);
                  if (cycles_ff == 3'd0 || (wrap_ff && !req_start_req && cycles_ff == 3'd1))
                     cycles_in = CYCLES_PER_BIT;
                  stage_in = ST_IDLE;
                  res_last = 1'b1;
               end
            endcase
         end

         // flip adds half a table turn
         sine_idx = phase_in[31:24] + {flip_in, 7'd0};
         res_sample = sine_at(sine_idx);
         res_active = 1'b1;

         phase_sum = {1'b0, phase_in} + {2'b0, phase_inc_ff};
         wrap_in = phase_sum[WORD_W];
         phase_in = phase_sum[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_IDLE;
         shift_ff <= '0;
         bits_ff <= '0;
         cycles_ff <= '0;
         phase_ff <= '0;
         wrap_ff <= 1'b0;
         flip_ff <= 1'b0;
         prev_ff <= 1'b0;
      end else if (accept) begin
         stage_ff <= stage_in;
         shift_ff <= shift_in;
         bits_ff <= bits_in;
         cycles_ff <= cycles_in;
         phase_ff <= phase_in;
         wrap_ff <= wrap_in;
         flip_ff <= flip_in;
         prev_ff <= prev_in;
      end
   end

   // response register drains the skid first; skid fills only while held
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_sample_ff <= skid_sample_ff;
            out_active_ff <= skid_active_ff;
            out_last_ff <= skid_last_ff;
         end else if (accept) begin
            out_sample_ff <= res_sample;
            out_active_ff <= res_active;
            out_last_ff <= res_last;
         end
      end else if (accept) begin
         skid_sample_ff <= res_sample;
         skid_active_ff <= res_active;
         skid_last_ff <= res_last;
      end
   end

endmodule

// ===== rtl/core/bbm_checker.sv =====
module bbm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [bbm_pkg::SAMPLE_W-1:0] rsp_sample,
   input logic                             rsp_active,
   input logic                             rsp_last
);
   import bbm_pkg::*;

   // held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last))
      else $error("held response changed");

   // idle samples are silent
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_sample == '0)
      else $error("idle sample not zero");

   // end of burst only inside a burst
   a_last_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_active)
      else $error("last flag outside a burst");

   // the skid fills only behind a full response register
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty response register");

   // reset empties both registers
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && !req_stall)
      else $error("response pending after reset");

endmodule

bind bpsk_burst_modulator_top bbm_checker u_bbm_checker (.*);

// ===== verif/bpsk_burst_modulator_top_test.sv =====
`timescale 1ns / 1ps

module bpsk_burst_modulator_top_test;
   import bbm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned MAX_IDLE = 17;

   typedef struct {
      sample_type sample;
      logic active;
      logic last;
   } modulator_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_start_req = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   sample_type rsp_sample;
   logic rsp_active;
   logic rsp_last;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PACKET_WORD;
   logic [WORD_W-1:0] csr_wdata = '0;

   bpsk_burst_modulator_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_req(req_start_req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample),
      .rsp_active(rsp_active),
      .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // stimulus and scoreboard storage
   logic pending_starts[$];
   modulator_sample_type expected_samples[$];
   int unsigned requests_sent = 0;
   int unsigned samples_checked = 0;
   int unsigned bursts_ended = 0;
   int unsigned error_count = 0;

   // predictor copy of the configuration and the burst state
   logic [WORD_W-1:0] cfg_packet = '0;
   logic [INC_W-1:0] cfg_phase_inc = PHASE_INC_RESET;
   logic [STAGE_W-1:0] burst_stage = ST_IDLE;
   logic [WORD_W-1:0] tx_shift = '0;
   logic [BITS_W-1:0] tx_bits_left = '0;
   logic [CYC_W-1:0] tx_cycles_left = '0;
   logic [WORD_W-1:0] carrier_phase = '0;
   logic carrier_wrapped = 1'b0;
   logic carrier_flip = 1'b0;
   logic tx_prev_bit = 1'b0;
   sample_type sine_lut [0:255];

   initial begin
      forever #4 clock = ~clock;
   end

   // load the next section: the first bit takes effect after one full bit time
   function automatic void load_section(input logic [WORD_W-1:0] word,
                                        input logic [BITS_W-1:0] count);
      tx_shift = word;
      tx_bits_left = count;
      tx_cycles_left = CYCLES_PER_BIT;
   endfunction

   // shift out one bit once its carrier cycles are used up; a bit change flips the carrier
   function automatic void shift_out_bit();
      logic next_bit;
      if (tx_cycles_left != '0) return;
      tx_cycles_left = CYCLES_PER_BIT;
      if (tx_bits_left == '0) return;
      tx_bits_left = tx_bits_left - 1'b1;
      next_bit = tx_shift[tx_bits_left[4:0]];
      if (next_bit != tx_prev_bit) begin
         tx_prev_bit = next_bit;
         carrier_flip = ~carrier_flip;
      end
   endfunction

   // compute the sample that one accepted request produces and queue it
   function automatic void predict_sample(input logic start);
      modulator_sample_type result;
      logic [7:0] lut_idx;
      logic [WORD_W:0] phase_sum;
      result.sample = '0;
      result.active = 1'b0;
      result.last = 1'b0;
      if (start) begin
         carrier_phase = '0;
         carrier_wrapped = 1'b0;
         load_section('0, BITS_W'(PRE_ZERO_BITS));
         burst_stage = ST_PRE;
         carrier_flip = 1'b0;
         tx_prev_bit = 1'b0;
      end
      // a carrier wrap counts down the bit timer, even when idle
      if (carrier_wrapped) begin
         carrier_wrapped = 1'b0;
         tx_cycles_left = tx_cycles_left - 1'b1;
      end
      if (burst_stage == ST_IDLE || burst_stage > ST_POST) begin
         expected_samples.push_back(result);
         return;
      end
      shift_out_bit();
      if (tx_bits_left == '0) begin
         case (burst_stage)
            ST_PRE: begin
               burst_stage = ST_SYNC;
               load_section(SYNC_PATTERN, BITS_W'(SYNC_BITS));
            end
            ST_SYNC: begin
               burst_stage = ST_WORD;
               load_section(cfg_packet, BITS_W'(PACKET_BITS));
            end
            ST_WORD: begin
               burst_stage = ST_XWORD;
               load_section(cfg_packet ^ XOR_MASK, BITS_W'(PACKET_BITS));
            end
            ST_XWORD: begin
               burst_stage = ST_CHECK;
               load_section(cfg_packet >> 16, BITS_W'(CHECK_BITS));
            end
            ST_CHECK: begin
               burst_stage = ST_POST;
               load_section('0, BITS_W'(POST_ZERO_BITS));
            end
            default: begin
               burst_stage = ST_IDLE;
               result.last = 1'b1;
            end
         endcase
      end
      lut_idx = carrier_phase[31:24] + {carrier_flip, 7'd0};
      result.sample = sine_lut[lut_idx];
      result.active = 1'b1;
      phase_sum = {1'b0, carrier_phase} + {2'b00, cfg_phase_inc};
      carrier_wrapped = phase_sum[WORD_W];
      carrier_phase = phase_sum[WORD_W-1:0];
      expected_samples.push_back(result);
   endfunction

   // Request driver: predict on acceptance, then present the next request after its gap.
   int unsigned req_gap = 0;
   logic req_quiet = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_start_req <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_sample(req_start_req);
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_starts.size() > 0) begin
               req_start_req <= pending_starts.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 39) == 0) req_quiet = ~req_quiet;
               req_gap = req_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted sample against the oldest prediction.
   int unsigned rsp_hold = 0;
   logic rsp_quiet = 1'b0;
   always @(posedge clock) begin
      modulator_sample_type want;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $error("response with no request outstanding: sample %0d", rsp_sample);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               samples_checked++;
               if (rsp_sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d", want.sample, rsp_sample);
                  error_count++;
               end
               if (rsp_active !== want.active) begin
                  $error("active: expected %0b, got %0b", want.active, rsp_active);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  error_count++;
               end
            end
            if (rsp_last === 1'b1) bursts_ended++;
            if ($urandom_range(0, 39) == 0) rsp_quiet = ~rsp_quiet;
            rsp_hold = rsp_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // queue requests; a start fires with odds of one in start_odds, never when zero
   task automatic queue_requests(input int unsigned count, input int unsigned start_odds);
      for (int unsigned i = 0; i < count; i++) begin
         pending_starts.push_back(start_odds != 0 &&
                                  $urandom_range(0, start_odds - 1) == 0);
      end
   endtask

   // wait until every request is accepted and every sample checked, then settle
   task automatic drain_responses();
      do @(negedge clock);
      while (pending_starts.size() > 0 || req_valid || expected_samples.size() > 0);
      repeat (4) @(negedge clock);
   endtask

   // write one register while the block is idle and mirror it in the predictor
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [WORD_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_PACKET_WORD) cfg_packet = data;
      else if (index == CSR_PHASE_INC) cfg_phase_inc = data[INC_W-1:0];
   endtask

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [WORD_W-1:0] rand_inc;
      // build the full-turn sine from the quarter wave
      for (int i = 0; i < 256; i++) begin
         if (i <= 64) sine_lut[i] = QUARTER_SINE[i];
         else if (i < 128) sine_lut[i] = QUARTER_SINE[128 - i];
         else if (i <= 192) sine_lut[i] = -QUARTER_SINE[i - 128];
         else sine_lut[i] = -QUARTER_SINE[256 - i];
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: idle samples, a start, restarts mid-burst and back to back
      queue_requests(3, 0);
      queue_requests(1, 1);
      queue_requests(6, 0);
      queue_requests(2, 1);
      queue_requests(5, 0);
      drain_responses();
      // a standing carrier: bit 31 of the write is dropped, leaving a zero step
      write_csr(CSR_PHASE_INC, 32'h8000_0000);
      queue_requests(1, 1);
      queue_requests(4, 0);
      drain_responses();

      // default carrier, random word, sparse restarts
      write_csr(CSR_PHASE_INC, {1'b0, PHASE_INC_RESET});
      write_csr(CSR_PACKET_WORD, $urandom());
      queue_requests(1, 1);
      queue_requests(150, 64);
      drain_responses();

      // slowest carrier
      write_csr(CSR_PHASE_INC, 32'd1);
      write_csr(CSR_PACKET_WORD, 32'h0000_0000);
      queue_requests(60, 16);
      drain_responses();

      // fastest carrier through preamble, sync and into the word; rewrite the
      // word mid-burst so that later sections load the new value
      write_csr(CSR_PHASE_INC, 32'h7fff_ffff);
      write_csr(CSR_PACKET_WORD, 32'hffff_ffff);
      queue_requests(1, 1);
      queue_requests(299, 0);
      drain_responses();
      write_csr(CSR_PACKET_WORD, $urandom());
      queue_requests(300, 0);
      drain_responses();

      // random settings with dense, moderate and rare restarts
      repeat (4) begin
         rand_inc = $urandom();
         if (rand_inc[INC_W-1:0] == '0) rand_inc = 32'd1;
         write_csr(CSR_PHASE_INC, rand_inc);
         write_csr(CSR_PACKET_WORD, $urandom());
         queue_requests(1, 1);
         case ($urandom_range(0, 2))
            0: queue_requests(60, 2);
            1: queue_requests(60, 16);
            default: queue_requests(60, 200);
         endcase
         drain_responses();
      end

      $display("checked %0d samples from %0d requests, %0d bursts ran to their final sample",
               samples_checked, requests_sent, bursts_ended);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
